// File: rtl/rsp_pkg.sv
`default_nettype none

package rsp_pkg;

    // Default width of a parsed decimal number before it saturates.
    localparam int POSITION_BITS_DEF = 16;

    // Widths fixed by the configuration registers and the result fields.
    localparam int CFG_WIDTH      = 16;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CHAR_WIDTH     = 8;
    localparam int OUT_VAL_WIDTH  = 17;
    localparam int OUT_DATA_WIDTH = 40;

    // Configuration register indexes.
    localparam logic [CFG_IDX_WIDTH-1:0] REG_LOWEST  = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_HIGHEST = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_CURRENT = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CFG_WIDTH-1:0] LOWEST_RESET  = 16'd1;
    localparam logic [CFG_WIDTH-1:0] HIGHEST_RESET = 16'hFFFF;
    localparam logic [CFG_WIDTH-1:0] CURRENT_RESET = 16'd1;

    // Characters with a meaning in a range string.
    localparam logic [CHAR_WIDTH-1:0] CHAR_DASH   = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CHAR_DOT    = 8'h2E;
    localparam logic [CHAR_WIDTH-1:0] CHAR_DOLLAR = 8'h24;
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_NINE   = 8'h39;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_END   = 2'd1,
        PH_DONE  = 2'd2
    } phase_t;

endpackage

`default_nettype wire

// File: rtl/range_spec_parser_unit.sv
`default_nettype none

// Range string parser: one character word per cycle, back to back; the input stalls
// only while a final character waits for a result word the receiver has not taken.
// The result word is registered: the result register loads from the input register
// when the final character held there advances.
// The parse step is a multiply-by-ten add with saturation between the two registers.
// Reset clears the parse state and loads the position registers with 1, 65535, 1.
module range_spec_parser_unit
    import rsp_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    // Configuration write channel.
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire logic [CFG_WIDTH-1:0]      cfg_data,

    // Character stream; s_tdata: text_char[7:0]; s_tlast: final_char.
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [CHAR_WIDTH-1:0]     s_tdata,
    input  wire logic                      s_tlast,

    // Result stream; m_tdata: range_ok[0], start_value[17:1], end_value[34:18],
    // zero padding[39:35].
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [OUT_DATA_WIDTH-1:0]      m_tdata
);

    // Width that holds both a parsed number and a position register value.
    localparam int VW  = (POSITION_BITS > CFG_WIDTH) ? POSITION_BITS : CFG_WIDTH;
    localparam int AW  = POSITION_BITS + 4;
    localparam logic [POSITION_BITS-1:0] LIMIT = '1;
    localparam int PAD = OUT_DATA_WIDTH - 1 - 2 * OUT_VAL_WIDTH;

    // Position registers.
    logic [CFG_WIDTH-1:0]     lowest_reg;
    logic [CFG_WIDTH-1:0]     highest_reg;
    logic [CFG_WIDTH-1:0]     current_reg;

    // Input register.
    logic                     in_valid_reg;
    logic [CHAR_WIDTH-1:0]    char_reg;
    logic                     last_reg;

    // Parse state; start and end hold all ones for "none given".
    phase_t                   phase_reg, phase_next;
    logic                     in_num_reg, in_num_next;
    logic [POSITION_BITS-1:0] acc_reg, acc_next;
    logic [VW:0]              start_reg, start_next;
    logic [VW:0]              end_reg, end_next;

    // Result register.
    logic                     out_valid_reg;
    logic                     ok_reg, ok_next;
    logic [OUT_VAL_WIDTH-1:0] start_out_reg;
    logic [OUT_VAL_WIDTH-1:0] end_out_reg;

    logic                     advance;
    logic                     is_digit;
    logic [AW-1:0]            acc_wide;
    logic [AW-1:0]            digit_wide;
    logic [AW-1:0]            prod;
    logic [POSITION_BITS-1:0] sat_val;
    logic [VW:0]              num_val;
    logic [VW:0]              cur_val;
    logic [VW:0]              high_val;
    logic [VW:0]              low_val;

    assign cfg_ready = 1'b1;

    // The input stage moves on unless its final character must wait for the result slot.
    assign advance  = in_valid_reg && (!last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD{1'b0}}, end_out_reg, start_out_reg, ok_reg};

    // Position register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_reg  <= LOWEST_RESET;
            highest_reg <= HIGHEST_RESET;
            current_reg <= CURRENT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LOWEST:  lowest_reg  <= cfg_data;
                REG_HIGHEST: highest_reg <= cfg_data;
                REG_CURRENT: current_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            char_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    // Decimal step: accumulator times ten plus digit, saturated.
    always_comb
    begin
        is_digit   = (char_reg >= CHAR_ZERO) && (char_reg <= CHAR_NINE);
        acc_wide   = {4'b0000, acc_reg};
        digit_wide = '0;
        digit_wide[3:0] = char_reg[3:0];
        prod = in_num_reg ? ((acc_wide << 3) + (acc_wide << 1) + digit_wide) : digit_wide;
        sat_val = (prod[AW-1:POSITION_BITS] != 4'b0000) ? LIMIT : prod[POSITION_BITS-1:0];
        num_val = '0;
        num_val[POSITION_BITS-1:0] = sat_val;
        cur_val  = '0;
        cur_val[CFG_WIDTH-1:0]  = current_reg;
        high_val = '0;
        high_val[CFG_WIDTH-1:0] = highest_reg;
        low_val  = '0;
        low_val[CFG_WIDTH-1:0]  = lowest_reg;
    end

    // Parse step for one character.
    always_comb
    begin
        phase_next  = phase_reg;
        in_num_next = in_num_reg;
        acc_next    = acc_reg;
        start_next  = start_reg;
        end_next    = end_reg;

        if (phase_reg != PH_DONE)
        begin
            if (is_digit)
            begin
                acc_next    = sat_val;
                in_num_next = 1'b1;
                if (phase_reg == PH_END)
                begin
                    end_next = num_val;
                end
                else
                begin
                    start_next = num_val;
                end
            end
            else if (in_num_reg && (phase_reg == PH_END))
            begin
                // The character that ends the end number is itself dropped.
                in_num_next = 1'b0;
                phase_next  = PH_DONE;
            end
            else
            begin
                in_num_next = 1'b0;
                unique case (char_reg)
                    CHAR_DASH:
                    begin
                        phase_next = PH_END;
                    end
                    CHAR_DOT:
                    begin
                        if (phase_reg == PH_END)
                        begin
                            end_next   = cur_val;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            start_next = cur_val;
                        end
                    end
                    CHAR_DOLLAR:
                    begin
                        if (phase_reg == PH_END)
                        begin
                            end_next   = high_val;
                            phase_next = PH_DONE;
                        end
                    end
                    default: ;
                endcase
            end
        end

        // Ordered and in bounds; a missing start or end fails.
        ok_next = !start_next[VW] && !end_next[VW] &&
                  (start_next >= low_val) && (end_next >= start_next) &&
                  (end_next <= high_val);
    end

    // Parse state registers; a final character returns them to reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            in_num_reg <= 1'b0;
            acc_reg    <= '0;
            start_reg  <= '1;
            end_reg    <= '1;
        end
        else if (advance)
        begin
            if (last_reg)
            begin
                phase_reg  <= PH_START;
                in_num_reg <= 1'b0;
                acc_reg    <= '0;
                start_reg  <= '1;
                end_reg    <= '1;
            end
            else
            begin
                phase_reg  <= phase_next;
                in_num_reg <= in_num_next;
                acc_reg    <= acc_next;
                start_reg  <= start_next;
                end_reg    <= end_next;
            end
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
        begin
            ok_reg        <= ok_next;
            start_out_reg <= start_next[OUT_VAL_WIDTH-1:0];
            end_out_reg   <= end_next[OUT_VAL_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire
